// File: src/ftpp_pkg.sv
// Package: shared types, constants and tables for the FTP command line parser.
`timescale 1ns / 1ps
package ftpp_pkg;

   localparam int NCMD = 22;
   localparam int ARG_MAX_LEN_DEF = 255;
   localparam int OFFSET_BITS_DEF = 63;
   localparam int OFS_W = 63;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_COMMA = 8'd44;

   localparam logic [4:0] CMD_PORT = 5'd6;
   localparam logic [4:0] CMD_TYPE = 5'd8;
   localparam logic [4:0] CMD_REST = 5'd19;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNREC = 2'd1;
   localparam logic [1:0] ST_PARAM = 2'd2;

   localparam logic KIND_STR = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      K_NONE, K_STR, K_OPT, K_HP, K_TYPE, K_STRU, K_MODE, K_OFS
   } arg_kind_type;

   typedef enum logic [4:0] {
      PH_NAME, PH_SKIP, PH_EOL, PH_SPACE, PH_OPT, PH_STR, PH_P_FIRST, PH_P_MORE,
      PH_T_LETTER, PH_T_AE, PH_T_FMT, PH_L_FIRST, PH_L_MORE, PH_STRU, PH_MODE,
      PH_R_FIRST, PH_R_MORE
   } phase_type;

   // result word handed from the step logic to the output register
   typedef struct packed {
      logic              item_kind;
      logic [7:0]        arg_byte;
      logic [1:0]        status;
      logic [4:0]        command_code;
      logic [1:0]        arg_count;
      logic [7:0]        first_letter;
      logic [7:0]        second_letter;
      logic [7:0]        byte_size;
      logic [31:0]       host_address;
      logic [15:0]       port_number;
      logic [OFS_W-1:0]  rest_offset;
      logic              line_end;
   } rsp_word_type;

   function automatic logic [7:0] name_char(input logic [4:0] i, input logic [1:0] p);
      logic [31:0] n;
      unique case (i)
         5'd0:  n = "AUTH";
         5'd1:  n = "USER";
         5'd2:  n = "PASS";
         5'd3:  n = {"CWD", 8'd0};
         5'd4:  n = "CDUP";
         5'd5:  n = "QUIT";
         5'd6:  n = "PORT";
         5'd7:  n = "PASV";
         5'd8:  n = "TYPE";
         5'd9:  n = "STRU";
         5'd10: n = "MODE";
         5'd11: n = "RETR";
         5'd12: n = "STOR";
         5'd13: n = {"PWD", 8'd0};
         5'd14: n = "LIST";
         5'd15: n = "NLST";
         5'd16: n = "SYST";
         5'd17: n = "HELP";
         5'd18: n = "NOOP";
         5'd19: n = "REST";
         5'd20: n = "SIZE";
         5'd21: n = "MDTM";
         default: n = '0;
      endcase
      return n[8*(3-p) +: 8];
   endfunction

   function automatic logic [2:0] name_len(input logic [4:0] i);
      return (i == 5'd3 || i == 5'd13) ? 3'd3 : 3'd4;
   endfunction

   function automatic arg_kind_type cmd_kind(input logic [4:0] i);
      arg_kind_type k;
      unique case (i)
         5'd0, 5'd1, 5'd2, 5'd3, 5'd11, 5'd12, 5'd20, 5'd21: k = K_STR;
         5'd14, 5'd15, 5'd17: k = K_OPT;
         5'd6:  k = K_HP;
         5'd8:  k = K_TYPE;
         5'd9:  k = K_STRU;
         5'd10: k = K_MODE;
         5'd19: k = K_OFS;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

endpackage

// File: src/ftpp_name_match.sv
// Command name matcher: narrows the candidate set by one name byte.
`timescale 1ns / 1ps
module ftpp_name_match (
   input  logic [ftpp_pkg::NCMD-1:0] mask_cur,
   input  logic [1:0]                position,
   input  logic [7:0]                upper_byte,
   output logic [ftpp_pkg::NCMD-1:0] mask_next,
   output logic                      hit,
   output logic [4:0]                hit_code
);
   import ftpp_pkg::*;

   logic [NCMD-1:0] full;

   always_comb begin
      for (int i = 0; i < NCMD; i++) begin
         mask_next[i] = mask_cur[i] && ({1'b0, position} < name_len(5'(i))) &&
                        (name_char(5'(i), position) == upper_byte);
         full[i] = mask_next[i] && (name_len(5'(i)) == {1'b0, position} + 3'd1);
      end
   end

   // lowest-index full match wins
   always_comb begin
      hit = 1'b0;
      hit_code = '0;
      for (int i = NCMD - 1; i >= 0; i--) begin
         if (full[i]) begin
            hit = 1'b1;
            hit_code = 5'(i);
         end
      end
   end

endmodule

// File: src/ftpp_step.sv
// Per-byte parser state machine with its registered state.
`timescale 1ns / 1ps
module ftpp_step #(
   parameter int ARG_MAX_LEN = ftpp_pkg::ARG_MAX_LEN_DEF,
   parameter int OFFSET_BITS = ftpp_pkg::OFFSET_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            data_byte,
   output logic                  has_rsp,
   output ftpp_pkg::rsp_word_type rsp
);
   import ftpp_pkg::*;

   localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'((65'd1 << OFFSET_BITS) - 65'd1);
   localparam logic [OFS_W-1:0] MAX_TEN = MAX_OFS / 10;
   localparam logic [3:0]       MAX_REM = 4'(MAX_OFS % 10);
   localparam logic [11:0]      STR_MAX = 12'(ARG_MAX_LEN);

   phase_type          phase_ff, phase_in;
   logic [1:0]         pos_ff, pos_in;
   logic [NCMD-1:0]    mask_ff, mask_in;
   logic [4:0]         cmd_ff, cmd_in;
   logic [1:0]         err_ff, err_in;
   logic [OFS_W-1:0]   acc_ff, acc_in;
   logic [2:0]         oct_ff, oct_in;
   logic [31:0]        addr_ff, addr_in;
   logic [15:0]        port_ff, port_in;
   logic [7:0]         let1_ff, let1_in;
   logic [7:0]         let2_ff, let2_in;
   logic [11:0]        slen_ff, slen_in;
   logic [1:0]         args_ff, args_in;

   logic [7:0]         up;
   logic [3:0]         dig;
   logic               is_lf;
   logic [NCMD-1:0]    mask_nx;
   logic               hit;
   logic [4:0]         hit_code;
   logic [OFS_W-1:0]   acc_x10;
   logic               small_ok;
   logic               ofs_ok;
   logic               start;
   logic               vfire;
   logic [1:0]         vstat;
   logic [1:0]         vargs;

   ftpp_name_match u_match (
      .mask_cur   (mask_ff),
      .position   (pos_ff),
      .upper_byte (up),
      .mask_next  (mask_nx),
      .hit        (hit),
      .hit_code   (hit_code)
   );

   assign up      = upcase(data_byte);
   assign dig     = data_byte[3:0] - 4'd0;
   assign is_lf   = data_byte == CH_LF;
   assign acc_x10 = (acc_ff << 3) + (acc_ff << 1);
   assign small_ok = (acc_ff[OFS_W-1:8] == '0) &&
                     ({4'b0, acc_ff[7:0]} * 12'd10 + 12'(dig) <= 12'd255);
   assign ofs_ok   = (acc_ff < MAX_TEN) || (acc_ff == MAX_TEN && dig <= MAX_REM);

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; mask_in = mask_ff; cmd_in = cmd_ff;
      err_in = err_ff; acc_in = acc_ff; oct_in = oct_ff; addr_in = addr_ff;
      port_in = port_ff; let1_in = let1_ff; let2_in = let2_ff;
      slen_in = slen_ff; args_in = args_ff;
      vfire = 1'b0; vstat = ST_OK; vargs = args_ff;
      has_rsp = 1'b0;
      rsp = '0;

      unique case (phase_ff)
         PH_NAME: begin
            mask_in = mask_nx;
            if (mask_nx == '0) begin
               if (is_lf) begin vfire = 1'b1; vstat = ST_UNREC; end
               else begin phase_in = PH_SKIP; err_in = ST_UNREC; end
            end else if (hit) begin
               cmd_in = hit_code;
               unique case (cmd_kind(hit_code))
                  K_NONE:  phase_in = PH_EOL;
                  K_OPT:   phase_in = PH_OPT;
                  default: phase_in = PH_SPACE;
               endcase
            end else begin
               pos_in = pos_ff + 2'd1;
            end
         end
         PH_SKIP: begin
            if (is_lf) begin vfire = 1'b1; vstat = err_ff; end
         end
         PH_EOL: begin
            if (is_lf) vfire = 1'b1;
            else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
         end
         PH_SPACE: begin
            if (data_byte == CH_SPACE) begin
               unique case (cmd_kind(cmd_ff))
                  K_STR:   phase_in = PH_STR;
                  K_HP:    phase_in = PH_P_FIRST;
                  K_TYPE:  phase_in = PH_T_LETTER;
                  K_STRU:  phase_in = PH_STRU;
                  K_MODE:  phase_in = PH_MODE;
                  default: phase_in = PH_R_FIRST;
               endcase
            end else if (is_lf) begin vfire = 1'b1; vstat = ST_PARAM; end
            else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
         end
         PH_OPT: begin
            if (is_lf) vfire = 1'b1;
            else if (data_byte == CH_SPACE) phase_in = PH_STR;
            else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
         end
         PH_STR: begin
            if (is_lf) begin vfire = 1'b1; vargs = 2'd1; end
            else if (data_byte == 8'd0 || slen_ff >= STR_MAX) begin
               phase_in = PH_SKIP; err_in = ST_PARAM;
            end else begin
               slen_in = slen_ff + 12'd1;
               has_rsp = 1'b1;
               rsp.item_kind = KIND_STR;
               rsp.arg_byte = data_byte;
               rsp.command_code = cmd_ff;
            end
         end
         PH_P_FIRST, PH_L_FIRST, PH_R_FIRST: begin
            if (!is_digit(data_byte)) begin
               if (is_lf) begin vfire = 1'b1; vstat = ST_PARAM; end
               else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
            end else begin
               acc_in = OFS_W'(dig);
               phase_in = (phase_ff == PH_P_FIRST) ? PH_P_MORE :
                          (phase_ff == PH_L_FIRST) ? PH_L_MORE : PH_R_MORE;
            end
         end
         PH_P_MORE, PH_L_MORE, PH_R_MORE: begin
            if (is_digit(data_byte)) begin
               if ((phase_ff == PH_R_MORE) ? ofs_ok : small_ok)
                  acc_in = acc_x10 + OFS_W'(dig);
               else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
            end else if (phase_ff == PH_P_MORE && data_byte == CH_COMMA &&
                         oct_ff < 3'd5) begin
               if (oct_ff < 3'd4) addr_in = {addr_ff[23:0], acc_ff[7:0]};
               else port_in = {port_ff[7:0], acc_ff[7:0]};
               oct_in = oct_ff + 3'd1;
               acc_in = '0;
               phase_in = PH_P_FIRST;
            end else if (is_lf && (phase_ff != PH_P_MORE || oct_ff == 3'd5)) begin
               vfire = 1'b1;
               if (phase_ff == PH_P_MORE) begin
                  port_in = {port_ff[7:0], acc_ff[7:0]};
                  vargs = 2'd1;
               end else begin
                  vargs = (phase_ff == PH_L_MORE) ? 2'd2 : 2'd1;
               end
            end else if (is_lf) begin vfire = 1'b1; vstat = ST_PARAM; end
            else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
         end
         PH_T_LETTER: begin
            if (up == "A" || up == "E") begin
               let1_in = up; args_in = 2'd1; phase_in = PH_T_AE;
            end else if (up == "I") begin
               let1_in = up; args_in = 2'd1; phase_in = PH_EOL;
            end else if (up == "L") begin
               let1_in = up; phase_in = PH_L_FIRST;
            end else if (is_lf) begin vfire = 1'b1; vstat = ST_PARAM; end
            else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
         end
         PH_T_AE: begin
            if (is_lf) vfire = 1'b1;
            else if (data_byte == CH_SPACE) phase_in = PH_T_FMT;
            else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
         end
         PH_T_FMT: begin
            if (up == "N" || up == "T" || up == "C") begin
               let2_in = up; args_in = 2'd2; phase_in = PH_EOL;
            end else if (is_lf) begin vfire = 1'b1; vstat = ST_PARAM; end
            else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
         end
         PH_STRU, PH_MODE: begin
            if ((phase_ff == PH_STRU && (up == "F" || up == "R" || up == "P")) ||
                (phase_ff == PH_MODE && (up == "S" || up == "B" || up == "C"))) begin
               let1_in = up; args_in = 2'd1; phase_in = PH_EOL;
            end else if (is_lf) begin vfire = 1'b1; vstat = ST_PARAM; end
            else begin phase_in = PH_SKIP; err_in = ST_PARAM; end
         end
         default: begin
            phase_in = PH_SKIP; err_in = ST_PARAM;
         end
      endcase

      if (vfire) begin
         has_rsp = 1'b1;
         rsp = '0;
         rsp.item_kind = KIND_VERDICT;
         rsp.line_end = 1'b1;
         rsp.status = vstat;
         if (vstat != ST_UNREC) rsp.command_code = cmd_ff;
         if (vstat == ST_OK) begin
            rsp.arg_count = vargs;
            rsp.first_letter = let1_ff;
            rsp.second_letter = let2_ff;
            if (cmd_ff == CMD_TYPE && let1_ff == "L") rsp.byte_size = acc_ff[7:0];
            if (cmd_ff == CMD_PORT) begin
               rsp.host_address = addr_ff;
               rsp.port_number = port_in;
            end
            if (cmd_ff == CMD_REST) rsp.rest_offset = acc_ff;
         end
      end
   end

   assign start = reset || (take && vfire);

   always_ff @(posedge clock) begin
      if (start) begin
         phase_ff <= PH_NAME; pos_ff <= '0; mask_ff <= '1; cmd_ff <= '0;
         err_ff <= '0; acc_ff <= '0; oct_ff <= '0; addr_ff <= '0;
         port_ff <= '0; let1_ff <= '0; let2_ff <= '0; slen_ff <= '0;
         args_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in; pos_ff <= pos_in; mask_ff <= mask_in;
         cmd_ff <= cmd_in; err_ff <= err_in; acc_ff <= acc_in;
         oct_ff <= oct_in; addr_ff <= addr_in; port_ff <= port_in;
         let1_ff <= let1_in; let2_ff <= let2_in; slen_ff <= slen_in;
         args_ff <= args_in;
      end
   end

endmodule

// File: src/ftp_command_line_parser_unit.sv
// Top level of the FTP command line parser: input register, parser, result register.
// Usage:
//  - req_valid/req_stall carry one byte (req_data_byte) of a control line per
//    word; a line ends with byte 10.
//  - rsp_valid/rsp_stall carry result words: one per string argument byte
//    (rsp_item_kind 0) and one verdict per line (rsp_item_kind 1).
//  - Path: a byte is captured in the input register, parsed combinationally
//    once the result register can take its result, and that result is
//    loaded into the result register, which drives rsp_valid.
//  - Throughput: one byte per cycle, set by the single parse step between
//    the input and result registers, unless rsp_stall holds the result register full.
//  - When rsp_stall holds the result register full, the input register
//    still takes one more byte; after that req_stall rises until the
//    result word is taken.
//  - Reset (synchronous, active high) clears both registers' valid flags and
//    returns the parser to the start of a line.
`timescale 1ns / 1ps
module ftp_command_line_parser_unit #(
   parameter int ARG_MAX_LEN = ftpp_pkg::ARG_MAX_LEN_DEF,
   parameter int OFFSET_BITS = ftpp_pkg::OFFSET_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_item_kind,
   output logic [7:0]                 rsp_arg_byte,
   output logic [1:0]                 rsp_status,
   output logic [4:0]                 rsp_command_code,
   output logic [1:0]                 rsp_arg_count,
   output logic [7:0]                 rsp_first_letter,
   output logic [7:0]                 rsp_second_letter,
   output logic [7:0]                 rsp_byte_size,
   output logic [31:0]                rsp_host_address,
   output logic [15:0]                rsp_port_number,
   output logic [ftpp_pkg::OFS_W-1:0] rsp_rest_offset,
   output logic                       rsp_line_end
);
   import ftpp_pkg::*;

   logic         in_vld_ff;
   logic [7:0]   in_byte_ff;
   logic         out_vld_ff;
   rsp_word_type out_ff;
   logic         take;
   logic         has_rsp;
   rsp_word_type rsp_w;

   // the parse step fires when the result register can take whatever it gives
   assign take      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !take;

   ftpp_step #(.ARG_MAX_LEN(ARG_MAX_LEN), .OFFSET_BITS(OFFSET_BITS)) u_step (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (in_byte_ff),
      .has_rsp   (has_rsp),
      .rsp       (rsp_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (!req_stall) in_vld_ff <= req_valid;
         if (take) out_vld_ff <= has_rsp;
         else if (!rsp_stall) out_vld_ff <= 1'b0;
      end
      if (!req_stall && req_valid) in_byte_ff <= req_data_byte;
      if (take && has_rsp) out_ff <= rsp_w;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_item_kind     = out_ff.item_kind;
   assign rsp_arg_byte      = out_ff.arg_byte;
   assign rsp_status        = out_ff.status;
   assign rsp_command_code  = out_ff.command_code;
   assign rsp_arg_count     = out_ff.arg_count;
   assign rsp_first_letter  = out_ff.first_letter;
   assign rsp_second_letter = out_ff.second_letter;
   assign rsp_byte_size     = out_ff.byte_size;
   assign rsp_host_address  = out_ff.host_address;
   assign rsp_port_number   = out_ff.port_number;
   assign rsp_rest_offset   = out_ff.rest_offset;
   assign rsp_line_end      = out_ff.line_end;

endmodule

// File: src/ftpp_checker.sv
// Port-level checker for the FTP command line parser, bound to the top level.
`timescale 1ns / 1ps
module ftpp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_item_kind,
   input logic [7:0] rsp_arg_byte,
   input logic [1:0] rsp_status,
   input logic [1:0] rsp_arg_count,
   input logic       rsp_line_end
);
   import ftpp_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_arg_byte))
      else $error("result word changed under stall");

   a_kind_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item_kind == rsp_line_end)
      else $error("line_end disagrees with item kind");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_PARAM)
      else $error("bad status");

   a_err_args: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_arg_count == 2'd0)
      else $error("error verdict with arguments");

   // an empty result register never holds back the input
   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

bind ftp_command_line_parser_unit ftpp_checker u_ftpp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_item_kind (rsp_item_kind),
   .rsp_arg_byte  (rsp_arg_byte),
   .rsp_status    (rsp_status),
   .rsp_arg_count (rsp_arg_count),
   .rsp_line_end  (rsp_line_end)
);
